// ===== rtl/core/fcr_pkg.sv =====
// ----------------------------------------------------------------------------
// fcr_pkg: shared types and constants for the fisheye coordinate remap core
// Beat structs, register indexes, fixed field widths and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package fcr_pkg;

  // Field widths fixed by the pixel and register formats
  localparam int DIM_W    = 12;            // pixel coordinate
  localparam int CDIM_W   = DIM_W + 1;     // image size register
  localparam int Q12_W    = 16;            // strength and zoom, unsigned Q4.12
  localparam int DX_W     = DIM_W + 2;     // signed offset from centre
  localparam int MAG_W    = DIM_W + 1;     // offset magnitude
  localparam int D2_W     = 2 * DIM_W + 1; // dx^2 + dy^2
  localparam int P1_W     = D2_W + Q12_W;  // d2 * S
  localparam int NUM1_W   = P1_W + Q12_W;  // d2 * S * S
  localparam int DIAG_W   = 2 * CDIM_W + 1;
  localparam int R2_W     = 54;            // saturated r^2, Q.24
  localparam int ROOT_W   = 31;            // r in Q.16
  localparam int ANG_W    = 31;            // nonnegative angle, Q.30
  localparam int NUM2_W   = ANG_W + 10;
  localparam int THETA_W  = 25;            // theta, Q.24, up to one
  localparam int OUT_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [THETA_W-1:0] THETA_ONE = 25'h100_0000;

  localparam int CORDIC_STEPS = 30;
  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_STRENGTH = 2'd2,
    REG_ZOOM     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] pixel_x;
    logic [DIM_W-1:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] source_x;
    logic signed [OUT_W-1:0] source_y;
    logic                    inside_border;
  } out_t;

  typedef struct packed {
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
  } dxy_t;

  // Travels alongside the root and arctangent pipes
  typedef struct packed {
    dxy_t               dxy;
    logic               bypass;    // theta_bp is final theta
    logic [THETA_W-1:0] theta_bp;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/core/fcr_front.sv =====
// ----------------------------------------------------------------------------
// fcr_front: centre offset and scaled squared radius
// Five register stages: capture, offset, square sum, two strength products.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire fcr_pkg::in_t                in_pix,
  input  wire logic [fcr_pkg::CDIM_W-1:0]  img_w,
  input  wire logic [fcr_pkg::CDIM_W-1:0]  img_h,
  input  wire logic [fcr_pkg::Q12_W-1:0]   strength,
  output logic                             out_valid,
  output logic [fcr_pkg::NUM1_W-1:0]       out_num,
  output fcr_pkg::dxy_t                    out_dxy
);
  import fcr_pkg::*;

  logic                  v0_r, v1_r, v2_r, v3_r, v4_r;
  in_t                   pix0_r;
  dxy_t                  dxy1_r, dxy2_r, dxy3_r, dxy4_r;
  logic [D2_W-1:0]       d2_r;
  logic [P1_W-1:0]       p1_r;
  logic [NUM1_W-1:0]     num_r;

  dxy_t                  dxy_nxt;
  logic signed [2*DX_W-1:0] sqx, sqy;
  logic [P1_W-1:0]       p1_nxt;
  logic [NUM1_W-1:0]     num_nxt;

  // (2p - size) / 2, truncated toward zero
  function automatic logic signed [DX_W-1:0] half_off(input logic [DIM_W-1:0] p,
                                                      input logic [CDIM_W-1:0] s);
    logic signed [DX_W:0] t;
    logic signed [DX_W:0] ta;
    t  = $signed({2'b00, p, 1'b0}) - $signed({2'b00, s});
    ta = t + (DX_W+1)'(t[DX_W]);
    return ta[DX_W:1];
  endfunction

  assign dxy_nxt.dx = half_off(pix0_r.pixel_x, img_w);
  assign dxy_nxt.dy = half_off(pix0_r.pixel_y, img_h);
  assign sqx        = dxy1_r.dx * dxy1_r.dx;
  assign sqy        = dxy1_r.dy * dxy1_r.dy;
  assign p1_nxt     = d2_r * strength;
  assign num_nxt    = p1_r * strength;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    pix0_r <= in_pix;
    dxy1_r <= dxy_nxt;
    dxy2_r <= dxy1_r;
    dxy3_r <= dxy2_r;
    dxy4_r <= dxy3_r;
    d2_r   <= D2_W'(sqx) + D2_W'(sqy);
    p1_r   <= p1_nxt;
    num_r  <= num_nxt;
  end

  assign out_valid = v4_r;
  assign out_num   = num_r;
  assign out_dxy   = dxy4_r;

endmodule

`default_nettype wire

// ===== rtl/core/fcr_udiv.sv =====
// ----------------------------------------------------------------------------
// fcr_udiv: pipelined unsigned restoring divider
// One quotient bit per register stage, NUM_W stages, side data carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_udiv #(
  parameter int NUM_W  = 57,
  parameter int DEN_W  = 27,
  parameter int SIDE_W = 28
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [NUM_W-1:0]       out_quo,
  output logic [SIDE_W-1:0]      out_side
);
  import fcr_pkg::*;

  logic              vld_r  [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  nsh_r  [NUM_W];
  logic [NUM_W-1:0]  quo_r  [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              vin;
    logic [DEN_W-1:0]  rin;
    logic [NUM_W-1:0]  nin;
    logic [NUM_W-1:0]  qin;
    logic [DEN_W-1:0]  din;
    logic [SIDE_W-1:0] sin;
    logic [DEN_W:0]    trial;
    logic              ge;
    logic [DEN_W-1:0]  rem_nxt;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign rin = '0;
      assign nin = in_num;
      assign qin = '0;
      assign din = in_den;
      assign sin = in_side;
    end else begin : g_next
      assign vin = vld_r[k-1];
      assign rin = rem_r[k-1];
      assign nin = nsh_r[k-1];
      assign qin = quo_r[k-1];
      assign din = den_r[k-1];
      assign sin = side_r[k-1];
    end

    assign trial   = {rin, nin[NUM_W-1]};
    assign ge      = trial >= {1'b0, din};
    assign rem_nxt = ge ? DEN_W'(trial - {1'b0, din}) : trial[DEN_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vin;
      end
      rem_r[k]  <= rem_nxt;
      nsh_r[k]  <= {nin[NUM_W-2:0], 1'b0};
      quo_r[k]  <= {qin[NUM_W-2:0], ge};
      den_r[k]  <= din;
      side_r[k] <= sin;
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign out_quo   = quo_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NUM_W-1] && den_r[NUM_W-1] != '0) |-> (rem_r[NUM_W-1] < den_r[NUM_W-1]))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// ===== rtl/core/fcr_isqrt.sv =====
// ----------------------------------------------------------------------------
// fcr_isqrt: pipelined integer square root
// One root bit per register stage, digit by digit, side data carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_isqrt #(
  parameter int ROOT_W = 31,
  parameter int SIDE_W = 54
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic [2*ROOT_W-1:0]   in_val,
  input  wire logic [SIDE_W-1:0]     in_side,
  output logic                       out_valid,
  output logic [ROOT_W-1:0]          out_root,
  output logic [SIDE_W-1:0]          out_side
);
  import fcr_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic                vld_r  [ROOT_W];
  logic [REM_W-1:0]    rem_r  [ROOT_W];
  logic [ROOT_W-1:0]   root_r [ROOT_W];
  logic [2*ROOT_W-1:0] vsh_r  [ROOT_W];
  logic [SIDE_W-1:0]   side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic                vin;
    logic [REM_W-1:0]    rin;
    logic [ROOT_W-1:0]   oin;
    logic [2*ROOT_W-1:0] vin_sh;
    logic [SIDE_W-1:0]   sin;
    logic [REM_W-1:0]    trial;
    logic [REM_W-1:0]    test;
    logic                ge;

    if (k == 0) begin : g_first
      assign vin    = in_valid;
      assign rin    = '0;
      assign oin    = '0;
      assign vin_sh = in_val;
      assign sin    = in_side;
    end else begin : g_next
      assign vin    = vld_r[k-1];
      assign rin    = rem_r[k-1];
      assign oin    = root_r[k-1];
      assign vin_sh = vsh_r[k-1];
      assign sin    = side_r[k-1];
    end

    assign trial = {rin[ROOT_W-1:0], vin_sh[2*ROOT_W-1 -: 2]};
    assign test  = {oin, 2'b01};
    assign ge    = trial >= test;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vin;
      end
      rem_r[k]  <= ge ? (trial - test) : trial;
      root_r[k] <= {oin[ROOT_W-2:0], ge};
      vsh_r[k]  <= {vin_sh[2*ROOT_W-3:0], 2'b00};
      side_r[k] <= sin;
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

  // floor root: what is left never exceeds twice the root
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ROOT_W-1] |-> (rem_r[ROOT_W-1] <= {1'b0, root_r[ROOT_W-1], 1'b0}))
    else $error("square root remainder too large");

endmodule

`default_nettype wire

// ===== rtl/core/fcr_cordic.sv =====
// ----------------------------------------------------------------------------
// fcr_cordic: pipelined vectoring CORDIC arctangent
// One micro-rotation per register stage, shifts truncate toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_cordic #(
  parameter int SIDE_W = 54
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [fcr_pkg::ROOT_W-1:0] in_rq,
  input  wire logic [SIDE_W-1:0]          in_side,
  output logic                            out_valid,
  output logic [fcr_pkg::ROOT_W-1:0]      out_rq,
  output logic [fcr_pkg::ANG_W-1:0]       out_ang,
  output logic [SIDE_W-1:0]               out_side
);
  import fcr_pkg::*;

  localparam int CW = 48;
  localparam int ZW = 32;

  logic                 vld_r  [CORDIC_STEPS];
  logic signed [CW-1:0] x_r    [CORDIC_STEPS];
  logic signed [CW-1:0] y_r    [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r    [CORDIC_STEPS];
  logic [ROOT_W-1:0]    rq_r   [CORDIC_STEPS];
  logic [SIDE_W-1:0]    side_r [CORDIC_STEPS];

  function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                  input int s);
    logic signed [CW-1:0] neg;
    neg = -v;
    return v[CW-1] ? -(neg >>> s) : (v >>> s);
  endfunction

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
    logic                 vin;
    logic signed [CW-1:0] xin, yin, sx, sy;
    logic signed [ZW-1:0] zin, at;
    logic [ROOT_W-1:0]    qin;
    logic [SIDE_W-1:0]    sin;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign xin = CW'(1) <<< 30;
      assign yin = $signed(CW'({in_rq, 14'b0}));
      assign zin = '0;
      assign qin = in_rq;
      assign sin = in_side;
    end else begin : g_next
      assign vin = vld_r[k-1];
      assign xin = x_r[k-1];
      assign yin = y_r[k-1];
      assign zin = z_r[k-1];
      assign qin = rq_r[k-1];
      assign sin = side_r[k-1];
    end

    assign sx = shr_tz(xin, k);
    assign sy = shr_tz(yin, k);
    assign at = $signed(ZW'(ATAN_TAB[k]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vin;
      end
      // rotate toward the x axis
      if (!yin[CW-1]) begin
        x_r[k] <= xin + sy;
        y_r[k] <= yin - sx;
        z_r[k] <= zin + at;
      end else begin
        x_r[k] <= xin - sy;
        y_r[k] <= yin + sx;
        z_r[k] <= zin - at;
      end
      rq_r[k]   <= qin;
      side_r[k] <= sin;
    end
  end

  assign out_valid = vld_r[CORDIC_STEPS-1];
  assign out_rq    = rq_r[CORDIC_STEPS-1];
  assign out_ang   = z_r[CORDIC_STEPS-1][ZW-1] ? '0 : z_r[CORDIC_STEPS-1][ANG_W-1:0];
  assign out_side  = side_r[CORDIC_STEPS-1];

  a_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[CORDIC_STEPS-1] |-> (x_r[CORDIC_STEPS-1] > 0))
    else $error("CORDIC x went nonpositive");

endmodule

`default_nettype wire

// ===== rtl/core/fcr_back.sv =====
// ----------------------------------------------------------------------------
// fcr_back: theta select, offset scaling, rounding and output
// Five register stages: select, two products, round and add, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_back #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [fcr_pkg::NUM2_W-1:0]  in_quo,
  input  wire fcr_pkg::side_t              in_side,
  input  wire logic [fcr_pkg::CDIM_W-1:0]  img_w,
  input  wire logic [fcr_pkg::CDIM_W-1:0]  img_h,
  input  wire logic [fcr_pkg::Q12_W-1:0]   zoom,
  output logic                             out_valid,
  output fcr_pkg::out_t                    out_res
);
  import fcr_pkg::*;

  localparam int PX_W  = THETA_W + MAG_W;
  localparam int ZX_W  = PX_W + Q12_W;
  localparam int SH    = 36 - FRAC_BITS;
  localparam int OFF_W = ZX_W + 1 - SH;
  localparam int SW    = (FRAC_BITS + 21 > 25) ? FRAC_BITS + 21 : 25;
  localparam logic signed [SW-1:0] ONE_Q  = SW'(1) <<< FRAC_BITS;
  localparam logic signed [SW-1:0] SAT_HI = SW'(8388607);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-8388608);

  logic                 v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [THETA_W-1:0]   theta_r;
  logic [MAG_W-1:0]     magx_r, magy_r;
  logic                 negx0_r, negy0_r, negx1_r, negy1_r, negx2_r, negy2_r;
  logic [PX_W-1:0]      px_r, py_r;
  logic [ZX_W-1:0]      zx_r, zy_r;
  logic signed [SW-1:0] sx_r, sy_r;
  out_t                 res_r;

  logic [THETA_W-1:0]   theta_nxt;
  logic [ZX_W:0]        rx, ry;
  logic [OFF_W-1:0]     offx, offy;
  logic signed [SW-1:0] cx, cy, sx_nxt, sy_nxt, lim_x, lim_y;
  out_t                 res_nxt;

  function automatic logic [MAG_W-1:0] mag(input logic signed [DX_W-1:0] d);
    logic signed [DX_W-1:0] n;
    n = -d;
    return d[DX_W-1] ? n[MAG_W-1:0] : d[MAG_W-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sat(input logic signed [SW-1:0] v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  always_comb begin
    if (in_side.bypass) begin
      theta_nxt = in_side.theta_bp;
    end else if (in_quo > NUM2_W'(THETA_ONE)) begin
      theta_nxt = THETA_ONE;
    end else begin
      theta_nxt = in_quo[THETA_W-1:0];
    end
  end

  // round half up in magnitude, then restore the sign
  assign rx     = {1'b0, zx_r} + ((ZX_W+1)'(1) << (SH - 1));
  assign ry     = {1'b0, zy_r} + ((ZX_W+1)'(1) << (SH - 1));
  assign offx   = rx[ZX_W:SH];
  assign offy   = ry[ZX_W:SH];
  assign cx     = $signed(SW'(img_w) << (FRAC_BITS - 1));
  assign cy     = $signed(SW'(img_h) << (FRAC_BITS - 1));
  assign sx_nxt = negx2_r ? cx - $signed(SW'(offx)) : cx + $signed(SW'(offx));
  assign sy_nxt = negy2_r ? cy - $signed(SW'(offy)) : cy + $signed(SW'(offy));

  assign lim_x = $signed(SW'(img_w) << FRAC_BITS) - ONE_Q;
  assign lim_y = $signed(SW'(img_h) << FRAC_BITS) - ONE_Q;

  always_comb begin
    res_nxt.source_x      = OUT_W'(sat(sx_r));
    res_nxt.source_y      = OUT_W'(sat(sy_r));
    res_nxt.inside_border = (sx_r > ONE_Q) && (sy_r > ONE_Q) &&
                            (sx_r < lim_x) && (sy_r < lim_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    theta_r <= theta_nxt;
    magx_r  <= mag(in_side.dxy.dx);
    magy_r  <= mag(in_side.dxy.dy);
    negx0_r <= in_side.dxy.dx[DX_W-1];
    negy0_r <= in_side.dxy.dy[DX_W-1];
    px_r    <= theta_r * magx_r;
    py_r    <= theta_r * magy_r;
    negx1_r <= negx0_r;
    negy1_r <= negy0_r;
    zx_r    <= px_r * zoom;
    zy_r    <= py_r * zoom;
    negx2_r <= negx1_r;
    negy2_r <= negy1_r;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    res_r   <= res_nxt;
  end

  assign out_valid = v4_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// ===== rtl/core/fisheye_coordinate_remap_core.sv =====
// ----------------------------------------------------------------------------
// fisheye_coordinate_remap_core: fisheye correction source coordinate map
// Maps an output pixel to its source position and an inside-border flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive in_data (pixel_x, pixel_y) with start high; it is taken
//   at any rising edge with start high and busy low. busy is always low, so
//   one beat per clock is sustained with no gaps.
//   Result beat: out_data (source_x, source_y in signed Q.FRAC_BITS, saturated
//   to 24 bits, plus inside_border) is shown for exactly one cycle with
//   out_valid high, in input order. There is no back-pressure: the receiver
//   must take every beat.
//   Depth: set by the bit-per-stage divider for r^2 (57 stages), the square
//   root (31), the 30 CORDIC rotations and the bit-per-stage divider for
//   atan(r)/r (41), plus front, small-radius and back stages.
//   Configuration: cfg_we writes cfg_wdata to register cfg_idx at the edge;
//   write only while no beat is in flight.
//   Reset (rst_n low, synchronous): flush every valid bit and load the
//   registers with 640 x 480, strength 1.0 and zoom 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module fisheye_coordinate_remap_core #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire fcr_pkg::in_t                    in_data,
  output logic                                 out_valid,
  output fcr_pkg::out_t                        out_data,
  input  wire logic                            cfg_we,
  input  wire logic [fcr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [fcr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fcr_pkg::*;

  localparam int LAT_FRONT = 5;
  localparam int LAT_SMALL = 3;
  localparam int LAT_BACK  = 5;
  localparam int LAT = LAT_FRONT + NUM1_W + LAT_SMALL + ROOT_W + CORDIC_STEPS +
                       NUM2_W + LAT_BACK;
  localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(1) <<< FRAC_BITS;

  // Configuration registers
  logic [CDIM_W-1:0] img_w_r, img_h_r;
  logic [Q12_W-1:0]  strength_r, zoom_r;
  // Diagonal squared; follows the size registers through w2_r/h2_r and
  // diag2_r, far ahead of any beat reaching the divider
  logic [2*CDIM_W-1:0] w2_r, h2_r;
  logic [DIAG_W-1:0]   diag2_r;

  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r    <= CDIM_W'(640);
      img_h_r    <= CDIM_W'(480);
      strength_r <= Q12_W'(4096);
      zoom_r     <= Q12_W'(4096);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_WIDTH:    img_w_r    <= cfg_wdata[CDIM_W-1:0];
        REG_HEIGHT:   img_h_r    <= cfg_wdata[CDIM_W-1:0];
        REG_STRENGTH: strength_r <= cfg_wdata;
        REG_ZOOM:     zoom_r     <= cfg_wdata;
        default: ;
      endcase
    end
    w2_r    <= img_w_r * img_w_r;
    h2_r    <= img_h_r * img_h_r;
    diag2_r <= DIAG_W'(w2_r) + DIAG_W'(h2_r);
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Front: offsets and d2 * S^2
  logic              fr_valid;
  logic [NUM1_W-1:0] fr_num;
  dxy_t              fr_dxy;

  fcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_pix    (in_data),
    .img_w     (img_w_r),
    .img_h     (img_h_r),
    .strength  (strength_r),
    .out_valid (fr_valid),
    .out_num   (fr_num),
    .out_dxy   (fr_dxy)
  );

  // r^2 = floor(d2 * S^2 / diag^2)
  logic              d1_valid;
  logic [NUM1_W-1:0] d1_quo;
  logic [$bits(dxy_t)-1:0] d1_side;
  dxy_t              d1_dxy;

  fcr_udiv #(
    .NUM_W  (NUM1_W),
    .DEN_W  (DIAG_W),
    .SIDE_W ($bits(dxy_t))
  ) u_div_r2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_num    (fr_num),
    .in_den    (diag2_r),
    .in_side   (fr_dxy),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_side  (d1_side)
  );
  assign d1_dxy = dxy_t'(d1_side);

  // Small radius: theta = 1 - r2/3 + (r2^2/2^24)/5, constant divides done as
  // reciprocal multiplies; a zero diagonal forces theta to one.
  logic              pa_v_r, pb_v_r, pc_v_r;
  dxy_t              pa_dxy_r, pb_dxy_r, pc_dxy_r;
  logic [R2_W-1:0]   pa_r2_r, pb_r2_r, pc_r2_r;
  logic              pa_small_r, pb_small_r, pa_unit_r, pb_unit_r;
  logic [32:0]       pa_t3p_r;
  logic [31:0]       pa_sqp_r;
  logic [15:0]       pb_t3_r, pb_t5p_r;
  logic              pc_bypass_r;
  logic [THETA_W-1:0] pc_theta_r;

  logic [R2_W-1:0]   r2_sat_nxt;
  logic [THETA_W-1:0] theta_small_nxt;

  // hold r^2 below 2^54 ahead of the root
  assign r2_sat_nxt = (d1_quo[NUM1_W-1:R2_W] != '0) ? {R2_W{1'b1}} : d1_quo[R2_W-1:0];
  assign theta_small_nxt = THETA_ONE - THETA_W'(pb_t3_r) + THETA_W'(pb_t5p_r[15:10]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_v_r <= 1'b0;
      pb_v_r <= 1'b0;
      pc_v_r <= 1'b0;
    end else begin
      pa_v_r <= d1_valid;
      pb_v_r <= pa_v_r;
      pc_v_r <= pb_v_r;
    end
    pa_dxy_r    <= d1_dxy;
    pa_r2_r     <= r2_sat_nxt;
    pa_small_r  <= d1_quo[NUM1_W-1:16] == '0;
    pa_unit_r   <= diag2_r == '0;
    pa_t3p_r    <= d1_quo[15:0] * 17'd43691;
    pa_sqp_r    <= d1_quo[15:0] * d1_quo[15:0];
    pb_dxy_r    <= pa_dxy_r;
    pb_r2_r     <= pa_r2_r;
    pb_small_r  <= pa_small_r;
    pb_unit_r   <= pa_unit_r;
    pb_t3_r     <= pa_t3p_r[32:17];
    pb_t5p_r    <= pa_sqp_r[31:24] * 8'd205;
    pc_dxy_r    <= pb_dxy_r;
    pc_r2_r     <= pb_r2_r;
    pc_bypass_r <= pb_unit_r || pb_small_r;
    pc_theta_r  <= pb_unit_r ? THETA_ONE : theta_small_nxt;
  end

  side_t pc_side;
  always_comb begin
    pc_side.dxy      = pc_dxy_r;
    pc_side.bypass   = pc_bypass_r;
    pc_side.theta_bp = pc_theta_r;
  end

  // r in Q.16
  logic                     sq_valid;
  logic [ROOT_W-1:0]        sq_root;
  logic [$bits(side_t)-1:0] sq_side;

  fcr_isqrt #(
    .ROOT_W (ROOT_W),
    .SIDE_W ($bits(side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pc_v_r),
    .in_val    ({pc_r2_r, 8'b0}),
    .in_side   (pc_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // atan(r)
  logic                     co_valid;
  logic [ROOT_W-1:0]        co_rq;
  logic [ANG_W-1:0]         co_ang;
  logic [$bits(side_t)-1:0] co_side;

  fcr_cordic #(
    .SIDE_W ($bits(side_t))
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_rq     (sq_root),
    .in_side   (sq_side),
    .out_valid (co_valid),
    .out_rq    (co_rq),
    .out_ang   (co_ang),
    .out_side  (co_side)
  );

  // theta = atan(r) * 2^10 / rq
  logic                     d2_valid;
  logic [NUM2_W-1:0]        d2_quo;
  logic [$bits(side_t)-1:0] d2_side;

  fcr_udiv #(
    .NUM_W  (NUM2_W),
    .DEN_W  (ROOT_W),
    .SIDE_W ($bits(side_t))
  ) u_div_theta (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (co_valid),
    .in_num    ({co_ang, 10'b0}),
    .in_den    (co_rq),
    .in_side   (co_side),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_side  (d2_side)
  );

  fcr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d2_valid),
    .in_quo    (d2_quo),
    .in_side   (side_t'(d2_side)),
    .img_w     (img_w_r),
    .img_h     (img_h_r),
    .zoom      (zoom_r),
    .out_valid (out_valid),
    .out_res   (out_data)
  );

  a_result_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result beat without matching input beat");

  a_inside_above_border: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.inside_border) |->
      (out_data.source_x > ONE_OUT && out_data.source_y > ONE_OUT))
    else $error("inside flag set on a border position");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised on a fully pipelined core");

endmodule

`default_nettype wire
